### hw/rtl/puct_pkg.sv
// ----------------------------------------------------------------------------
// puct_pkg: PUCT child selector package
// Field widths, score limits and defaults shared by the selector RTL.
// ----------------------------------------------------------------------------
package puct_pkg;

   localparam int unsigned VISITS_W  = 20;
   localparam int unsigned WINSUM_W  = 38;
   localparam int unsigned PRIOR_W   = 17;
   localparam int unsigned UNVIS_W   = 18;
   localparam int unsigned INDEX_W   = 10;
   localparam int unsigned SCORE_W   = 28;

   // Default node fan-out bound
   localparam int unsigned MAX_CHILDREN_DEF = 1024;

   // Score saturation: 1025 * 2^16
   localparam logic signed [39:0] SCORE_LIMIT = 40'sd67174400;

   // Reset value of the running maximum: most negative 28-bit value
   localparam logic signed [SCORE_W-1:0] MAX_RESET = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

### hw/rtl/puct_child_select.sv
// ----------------------------------------------------------------------------
// puct_child_select: PUCT child selector
// Scores each streamed child with Q + prior*sqrt(N+1)/(n+1) and reports the
// earliest highest-scoring child on the last child of a node.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  req     | in        | req_valid/ready    | visits, win_sum, prior, parent visits, last
//  rsp     | out       | rsp_valid/ready    | best_child, best_score
//  csr     | in        | csr_write_en       | unvisited_value
//
//  Each child goes through an accept, 27 root steps, 38 Q divide steps, a
//  multiply, 44 U divide steps and an update; the root and divide steps
//  share one compare/subtract unit. Unvisited children skip the Q divide.
//  Reset is synchronous; it resets the running maximum and clears the index,
//  count and unvisited_value register. A last child waits in the update
//  step while a previous result has not yet been taken on rsp.
// ----------------------------------------------------------------------------
module puct_child_select
   import puct_pkg::*;
#(
   parameter int unsigned MAX_CHILDREN = MAX_CHILDREN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [VISITS_W-1:0]        req_child_visits,
   input  logic signed [WINSUM_W-1:0] req_child_win_sum,
   input  logic [PRIOR_W-1:0]         req_prior,
   input  logic [VISITS_W-1:0]        req_parent_visits,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [INDEX_W-1:0]         rsp_best_child,
   output logic signed [SCORE_W-1:0]  rsp_best_score,
   input  logic                       csr_write_en,
   input  logic signed [UNVIS_W-1:0]  csr_write_data
);

   localparam int unsigned CNT_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHILDREN - 1);

   localparam int unsigned NUM_W  = 54;
   localparam int unsigned REM_W  = 30;
   localparam int unsigned ROOT_W = 27;
   localparam int unsigned PROD_W = PRIOR_W + ROOT_W;

   localparam logic [5:0] SQRT_LAST = 6'd26;
   localparam logic [5:0] QDIV_LAST = 6'd37;
   localparam logic [5:0] UDIV_LAST = 6'd43;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQRT, ST_QDIV, ST_MUL, ST_UDIV, ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [5:0]                step_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [VISITS_W-1:0]       visits_ff;
   logic                      neg_ff;
   logic [WINSUM_W-1:0]       mag_ff;
   logic [PRIOR_W-1:0]        prior_ff;
   logic                      last_ff;
   logic signed [38:0]        q_ff;
   logic [SCORE_W-1:0]        u_ff;
   logic signed [UNVIS_W-1:0] unvis_ff;
   logic signed [SCORE_W-1:0] run_max_ff;
   logic [CNT_W-1:0]          run_idx_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      rsp_valid_ff;
   logic [INDEX_W-1:0]        best_child_ff;
   logic signed [SCORE_W-1:0] best_score_ff;

   // Shared compare/subtract unit, root or divide mode
   logic                      sqrt_mode;
   logic [VISITS_W:0]         div_d;
   logic [REM_W-1:0]          rem_sh;
   logic [REM_W-1:0]          sub_val;
   logic [REM_W:0]            diff;
   logic                      ge;
   logic [REM_W-1:0]          rem_in;
   logic [NUM_W-1:0]          num_in;
   logic [ROOT_W-1:0]         root_in;

   always_comb begin
      sqrt_mode = (state_ff == ST_SQRT);
      div_d     = (state_ff == ST_UDIV) ? ({1'b0, visits_ff} + 21'd1) : {1'b0, visits_ff};
      if (sqrt_mode) begin
         rem_sh  = {rem_ff[REM_W-3:0], num_ff[NUM_W-1:NUM_W-2]};
         sub_val = {1'b0, root_ff, 2'b01};
      end else begin
         rem_sh  = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
         sub_val = REM_W'(div_d);
      end
      diff    = {1'b0, rem_sh} - {1'b0, sub_val};
      ge      = ~diff[REM_W];
      rem_in  = ge ? diff[REM_W-1:0] : rem_sh;
      root_in = {root_ff[ROOT_W-2:0], ge};
      num_in  = sqrt_mode ? {num_ff[NUM_W-3:0], 2'b00} : {num_ff[NUM_W-2:0], ge};
   end

   // Score assembly and saturation
   logic signed [39:0]        sum;
   logic signed [SCORE_W-1:0] score;
   logic [PROD_W-1:0]         prod;
   logic [CNT_W+INDEX_W-1:0]  idx_wide;
   logic [CNT_W-1:0]          win_idx;
   logic signed [SCORE_W-1:0] win_max;
   logic [WINSUM_W-1:0]       qmag;
   logic                      emit;

   always_comb begin
      sum = 40'(q_ff) + $signed({12'b0, u_ff});
      if (sum > SCORE_LIMIT)       score = SCORE_W'(SCORE_LIMIT);
      else if (sum < -SCORE_LIMIT) score = SCORE_W'(-SCORE_LIMIT);
      else                         score = sum[SCORE_W-1:0];
      prod = PROD_W'(prior_ff) * PROD_W'(root_ff);
      if (score > run_max_ff) begin
         win_max = score;
         win_idx = count_ff;
      end else begin
         win_max = run_max_ff;
         win_idx = run_idx_ff;
      end
      idx_wide = {{INDEX_W{1'b0}}, win_idx};
      qmag     = num_in[WINSUM_W-1:0];
   end

   // last child hands its word over once the rsp slot is free
   assign emit = (state_ff == ST_DONE) && last_ff && (!rsp_valid_ff || rsp_ready);

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_child = best_child_ff;
   assign rsp_best_score = best_score_ff;

   // Sequencer, running state and output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         unvis_ff     <= '0;
         run_max_ff   <= MAX_RESET;
         run_idx_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) unvis_ff <= csr_write_data;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  visits_ff <= req_child_visits;
                  neg_ff    <= req_child_win_sum[WINSUM_W-1];
                  mag_ff    <= req_child_win_sum[WINSUM_W-1]
                               ? WINSUM_W'(-req_child_win_sum)
                               : WINSUM_W'(req_child_win_sum);
                  prior_ff  <= req_prior;
                  last_ff   <= req_last;
                  num_ff    <= {1'b0, {1'b0, req_parent_visits} + 21'd1, 32'b0};
                  rem_ff    <= '0;
                  root_ff   <= '0;
                  step_ff   <= '0;
                  state_ff  <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               root_ff <= root_in;
               if (step_ff == SQRT_LAST) begin
                  step_ff <= '0;
                  rem_ff  <= '0;
                  if (visits_ff == '0) begin
                     q_ff     <= 39'(unvis_ff);
                     state_ff <= ST_MUL;
                  end else begin
                     num_ff   <= {mag_ff, 16'b0};
                     state_ff <= ST_QDIV;
                  end
               end else begin
                  rem_ff  <= rem_in;
                  num_ff  <= num_in;
                  step_ff <= step_ff + 6'd1;
               end
            end
            ST_QDIV: begin
               rem_ff  <= rem_in;
               num_ff  <= num_in;
               step_ff <= step_ff + 6'd1;
               if (step_ff == QDIV_LAST) begin
                  q_ff     <= neg_ff ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               num_ff   <= {prod, 10'b0};
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= ST_UDIV;
            end
            ST_UDIV: begin
               rem_ff  <= rem_in;
               num_ff  <= num_in;
               step_ff <= step_ff + 6'd1;
               if (step_ff == UDIV_LAST) begin
                  u_ff     <= num_in[PROD_W-1:16];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!last_ff) begin
                  run_max_ff <= win_max;
                  run_idx_ff <= win_idx;
                  if (count_ff != CNT_MAX) count_ff <= count_ff + 1'b1;
                  state_ff   <= ST_IDLE;
               end else if (emit) begin
                  best_child_ff <= idx_wide[INDEX_W-1:0];
                  best_score_ff <= win_max;
                  run_max_ff    <= MAX_RESET;
                  run_idx_ff    <= '0;
                  count_ff      <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
